// ----- sv/frx_pkg.sv -----
// ----------------------------------------------------------------------------
// frx_pkg: shared definitions for the framed serial packet receiver
// Frame layout constants, status codes, register indexes and the request and
// result types passed between the stages of the receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

    localparam int CFG_W       = 16;
    localparam int POS_W       = 5;
    localparam int IDX_W       = 4;
    localparam int PAYLOAD_LEN = 15;
    localparam int NUM_AREAS   = 4;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'h55;
    localparam logic [7:0] MODE_MIN   = 8'd1;
    localparam logic [7:0] MODE_MAX   = 8'd4;

    localparam logic [POS_W-1:0] FIRST_PAYLOAD_POS = 5'd1;
    localparam logic [POS_W-1:0] LAST_PAYLOAD_POS  = 5'd15;
    localparam logic [POS_W-1:0] CHECK_POS         = 5'd16;
    localparam logic [POS_W-1:0] END_POS           = 5'd17;
    localparam logic [POS_W-1:0] FRAME_POS         = 5'd18;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [CFG_W-1:0] MAX_SPEED_RESET = 16'd15000;

    localparam logic REG_TIMEOUT   = 1'b0;
    localparam logic REG_MAX_SPEED = 1'b1;

    localparam logic [2:0] STATUS_NONE     = 3'd0;
    localparam logic [2:0] STATUS_ACCEPTED = 3'd1;
    localparam logic [2:0] STATUS_CHECKSUM = 3'd2;
    localparam logic [2:0] STATUS_INVALID  = 3'd3;
    localparam logic [2:0] STATUS_OVERLONG = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_FRAME
    } frx_state_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } frx_item_t;

    typedef struct packed {
        logic [2:0]                  status;
        logic                        timed_out;
        logic [7:0]                  pwm;
        logic [2:0]                  ball_mode;
        logic [2:0]                  area_mode;
        logic [31:0]                 area_pwms;
        logic [NUM_AREAS-1:0][15:0]  area_speeds;
    } frx_result_t;

endpackage

// ----- sv/framed_serial_packet_receiver.sv -----
// ----------------------------------------------------------------------------
// framed_serial_packet_receiver: byte-stream frame receiver with checksum
// Assembles 18-byte frames (start 0xAA, 15 payload bytes, checksum, end 0x55)
// and keeps the record of the last valid frame.
// ----------------------------------------------------------------------------
// Each request carries one received byte and its arrival time and produces
// exactly one result. The byte is held in the input register and its result
// is registered in the result register before it appears on the outputs; a
// stalled output holds the byte in the input register. One request is accepted every clock
// cycle while the output is not stalled, the rate being set by the frame core
// updating the frame position, gap timer and running checksum as each byte is
// taken. The result gives the frame status, the timeout flag and the held
// record as it stands after that byte.
module framed_serial_packet_receiver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [frx_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    input  logic [31:0]                 now_ms,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic                        timed_out,
    output logic [7:0]                  pwm_out,
    output logic [2:0]                  ball_mode,
    output logic [2:0]                  area_mode,
    output logic [31:0]                 area_pwms,
    output logic [15:0]                 area_speed_0,
    output logic [15:0]                 area_speed_1,
    output logic [15:0]                 area_speed_2,
    output logic [15:0]                 area_speed_3
);
    import frx_pkg::*;

    frx_item_t   in_item;
    frx_item_t   item;
    logic        item_valid;
    logic        res_space;
    logic        fire;
    frx_result_t res;
    frx_result_t out_res;

    assign in_item.rx_byte = rx_byte;
    assign in_item.now_ms  = now_ms;
    assign fire            = item_valid && res_space;

    frx_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (fire),
        .item       (item)
    );

    frx_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (res)
    );

    frx_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res_space (res_space),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status       = out_res.status;
    assign timed_out    = out_res.timed_out;
    assign pwm_out      = out_res.pwm;
    assign ball_mode    = out_res.ball_mode;
    assign area_mode    = out_res.area_mode;
    assign area_pwms    = out_res.area_pwms;
    assign area_speed_0 = out_res.area_speeds[0];
    assign area_speed_1 = out_res.area_speeds[1];
    assign area_speed_2 = out_res.area_speeds[2];
    assign area_speed_3 = out_res.area_speeds[3];

endmodule

// ----- sv/frx_in_reg.sv -----
// ----------------------------------------------------------------------------
// frx_in_reg: input request register
// Captures one received byte and its timestamp and holds it until the frame
// core takes it, accepting a new request in the same cycle.
// ----------------------------------------------------------------------------
module frx_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  frx_pkg::frx_item_t  in_item,
    output logic                item_valid,
    input  logic                item_take,
    output frx_pkg::frx_item_t  item
);
    import frx_pkg::*;

    logic      valid_reg;
    frx_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- sv/frx_frame_core.sv -----
// ----------------------------------------------------------------------------
// frx_frame_core: frame tracking, checksum and held record
// Tracks the frame position, gap timeout and running checksum, stores the
// payload, checks a completed frame and updates the held record.
// ----------------------------------------------------------------------------
module frx_frame_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [frx_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        fire,
    input  frx_pkg::frx_item_t          item,
    output frx_pkg::frx_result_t        result
);
    import frx_pkg::*;

    frx_state_t                 state_reg;
    frx_state_t                 state_next;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;
    logic [31:0]                last_ms_reg;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic [7:0]                 check_reg;
    logic [7:0]                 check_next;
    logic [7:0]                 payload_reg [PAYLOAD_LEN];
    logic                       pay_we;
    logic [IDX_W-1:0]           pay_idx;
    logic [CFG_W-1:0]           timeout_reg;
    logic [CFG_W-1:0]           max_speed_reg;

    logic [7:0]                 held_pwm_reg;
    logic [7:0]                 held_pwm_next;
    logic [2:0]                 held_ball_reg;
    logic [2:0]                 held_ball_next;
    logic [2:0]                 held_area_reg;
    logic [2:0]                 held_area_next;
    logic [31:0]                held_pwms_reg;
    logic [31:0]                held_pwms_next;
    logic [NUM_AREAS-1:0][15:0] held_speeds_reg;
    logic [NUM_AREAS-1:0][15:0] held_speeds_next;

    logic [31:0]                gap;
    logic                       abort;
    logic                       active;
    logic                       in_payload;
    logic                       at_check;
    logic                       at_end;
    logic                       overlong;
    logic                       csum_ok;
    logic                       modes_ok;
    logic                       speeds_ok;
    logic [NUM_AREAS-1:0][15:0] frame_speeds;
    logic [2:0]                 status;

    assign gap        = item.now_ms - last_ms_reg;
    assign abort      = (state_reg == ST_FRAME) && (gap > {16'd0, timeout_reg});
    assign active     = (state_reg == ST_FRAME) && !abort;
    assign in_payload = (pos_reg >= FIRST_PAYLOAD_POS) && (pos_reg <= LAST_PAYLOAD_POS);
    assign at_check   = (pos_reg == CHECK_POS);
    assign at_end     = (pos_reg == END_POS) && (item.rx_byte == END_BYTE);
    assign overlong   = (pos_reg >= FRAME_POS);
    assign pay_idx    = pos_reg[IDX_W-1:0] - IDX_W'(1);

    always_comb
    begin
        for (int k = 0; k < NUM_AREAS; k++)
        begin
            frame_speeds[k] = {payload_reg[8 + 2 * k], payload_reg[7 + 2 * k]};
        end
    end

    assign csum_ok  = (check_reg == ~sum_reg);
    assign modes_ok = (payload_reg[1] inside {[MODE_MIN:MODE_MAX]})
                   && (payload_reg[2] inside {[MODE_MIN:MODE_MAX]});

    always_comb
    begin
        speeds_ok = 1'b1;
        for (int k = 0; k < NUM_AREAS; k++)
        begin
            if (frame_speeds[k] > max_speed_reg)
            begin
                speeds_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (!active)
        begin
            state_next = (item.rx_byte == START_BYTE) ? ST_FRAME : ST_IDLE;
        end
        else if (overlong || at_end)
        begin
            state_next = ST_IDLE;
        end
        else
        begin
            state_next = ST_FRAME;
        end
    end

    always_comb
    begin
        pos_next         = pos_reg;
        sum_next         = sum_reg;
        check_next       = check_reg;
        pay_we           = 1'b0;
        status           = STATUS_NONE;
        held_pwm_next    = held_pwm_reg;
        held_ball_next   = held_ball_reg;
        held_area_next   = held_area_reg;
        held_pwms_next   = held_pwms_reg;
        held_speeds_next = held_speeds_reg;
        if (!active)
        begin
            if (item.rx_byte == START_BYTE)
            begin
                pos_next = FIRST_PAYLOAD_POS;
                sum_next = 8'd0;
            end
            else
            begin
                pos_next = '0;
            end
        end
        else if (overlong)
        begin
            pos_next = '0;
            status   = STATUS_OVERLONG;
        end
        else
        begin
            if (in_payload)
            begin
                pay_we   = 1'b1;
                sum_next = sum_reg + item.rx_byte;
            end
            else if (at_check)
            begin
                check_next = item.rx_byte;
            end
            pos_next = pos_reg + POS_W'(1);
            if (at_end)
            begin
                pos_next = '0;
                if (!csum_ok)
                begin
                    status = STATUS_CHECKSUM;
                end
                else if (!modes_ok || !speeds_ok)
                begin
                    status = STATUS_INVALID;
                end
                else
                begin
                    status           = STATUS_ACCEPTED;
                    held_pwm_next    = payload_reg[0];
                    held_ball_next   = payload_reg[1][2:0];
                    held_area_next   = payload_reg[2][2:0];
                    held_pwms_next   = {payload_reg[6], payload_reg[5],
                                        payload_reg[4], payload_reg[3]};
                    held_speeds_next = frame_speeds;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            last_ms_reg     <= '0;
            sum_reg         <= '0;
            check_reg       <= '0;
            held_pwm_reg    <= '0;
            held_ball_reg   <= 3'd1;
            held_area_reg   <= 3'd1;
            held_pwms_reg   <= '0;
            held_speeds_reg <= '0;
        end
        else if (fire)
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            last_ms_reg     <= item.now_ms;
            sum_reg         <= sum_next;
            check_reg       <= check_next;
            held_pwm_reg    <= held_pwm_next;
            held_ball_reg   <= held_ball_next;
            held_area_reg   <= held_area_next;
            held_pwms_reg   <= held_pwms_next;
            held_speeds_reg <= held_speeds_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            max_speed_reg <= MAX_SPEED_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TIMEOUT:   timeout_reg   <= cfg_data;
                REG_MAX_SPEED: max_speed_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && pay_we)
        begin
            payload_reg[pay_idx] <= item.rx_byte;
        end
    end

    assign result.status      = status;
    assign result.timed_out   = abort;
    assign result.pwm         = held_pwm_next;
    assign result.ball_mode   = held_ball_next;
    assign result.area_mode   = held_area_next;
    assign result.area_pwms   = held_pwms_next;
    assign result.area_speeds = held_speeds_next;

endmodule

// ----- sv/frx_out_reg.sv -----
// ----------------------------------------------------------------------------
// frx_out_reg: result register
// Holds one result until the consumer takes it and tells the frame core when
// the next result may be loaded.
// ----------------------------------------------------------------------------
module frx_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    output logic                  res_space,
    input  frx_pkg::frx_result_t  res,
    output logic                  out_valid,
    input  logic                  out_ready,
    output frx_pkg::frx_result_t  out_res
);
    import frx_pkg::*;

    logic        valid_reg;
    frx_result_t res_reg;

    assign res_space = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_space)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_space && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the framed serial packet receiver
// Drives received bytes with millisecond stamps through the request channel,
// predicts every result from a behavioural model of the frame receiver and
// compares each result field by field. The run covers directed frames, random
// good, corrupt, overlong and truncated frames under several limit settings,
// output back-pressure and sender pauses.
// ----------------------------------------------------------------------------
module tb_top;

    import frx_pkg::*;

    typedef enum {
        FK_GOOD,
        FK_BAD_SUM,
        FK_BAD_BALL,
        FK_BAD_AREA,
        FK_FAST,
        FK_OVERLONG,
        FK_TRUNCATED,
        FK_NOISE
    } frame_kind_t;

    typedef enum {
        GAP_KEEP,
        GAP_ABORT,
        GAP_FREE
    } gap_mode_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_index = REG_TIMEOUT;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic [7:0]       rx_byte   = '0;
    logic [31:0]      now_ms    = '0;
    logic             out_ready = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  status;
    logic        timed_out;
    logic [7:0]  pwm_out;
    logic [2:0]  ball_mode;
    logic [2:0]  area_mode;
    logic [31:0] area_pwms;
    logic [15:0] area_speed_0;
    logic [15:0] area_speed_1;
    logic [15:0] area_speed_2;
    logic [15:0] area_speed_3;

    framed_serial_packet_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .timed_out    (timed_out),
        .pwm_out      (pwm_out),
        .ball_mode    (ball_mode),
        .area_mode    (area_mode),
        .area_pwms    (area_pwms),
        .area_speed_0 (area_speed_0),
        .area_speed_1 (area_speed_1),
        .area_speed_2 (area_speed_2),
        .area_speed_3 (area_speed_3)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    logic [CFG_W-1:0] lim_timeout = TIMEOUT_RESET;
    logic [CFG_W-1:0] lim_speed   = MAX_SPEED_RESET;
    logic             pr_in_frame = 1'b0;
    logic [POS_W-1:0] pr_pos      = '0;
    logic [31:0]      pr_last     = '0;
    logic [7:0]       pr_sum      = '0;
    logic [7:0]       pr_check    = '0;
    logic [7:0]       pr_payload [PAYLOAD_LEN];
    frx_result_t      held_rec;

    frx_result_t pending_results [$];
    logic [7:0]  pl [PAYLOAD_LEN];
    logic [31:0] clock_ms       = '0;
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          rx_hold        = 0;
    int          rx_stall       = 0;
    bit          quiet_tx       = 1'b0;
    bit          quiet_rx       = 1'b0;
    bit          drain_mode     = 1'b0;

    function automatic logic [2:0] judge_frame();
        logic [15:0] spd [NUM_AREAS];
        int          k;
        for (k = 0; k < NUM_AREAS; k++)
        begin
            spd[k] = {pr_payload[8 + 2 * k], pr_payload[7 + 2 * k]};
        end
        if (pr_check != 8'(8'hFF - pr_sum))
        begin
            return STATUS_CHECKSUM;
        end
        if (pr_payload[1] < MODE_MIN || pr_payload[1] > MODE_MAX)
        begin
            return STATUS_INVALID;
        end
        if (pr_payload[2] < MODE_MIN || pr_payload[2] > MODE_MAX)
        begin
            return STATUS_INVALID;
        end
        for (k = 0; k < NUM_AREAS; k++)
        begin
            if (spd[k] > lim_speed)
            begin
                return STATUS_INVALID;
            end
        end
        held_rec.pwm       = pr_payload[0];
        held_rec.ball_mode = pr_payload[1][2:0];
        held_rec.area_mode = pr_payload[2][2:0];
        held_rec.area_pwms = {pr_payload[6], pr_payload[5], pr_payload[4], pr_payload[3]};
        for (k = 0; k < NUM_AREAS; k++)
        begin
            held_rec.area_speeds[k] = spd[k];
        end
        return STATUS_ACCEPTED;
    endfunction

    function automatic frx_result_t rx_outcome(input logic [7:0] b, input logic [31:0] t);
        frx_result_t r;
        logic [31:0] since;
        logic [2:0]  st;
        logic        aborted;
        st      = STATUS_NONE;
        aborted = 1'b0;
        since   = t - pr_last;
        if (pr_in_frame && since > 32'(lim_timeout))
        begin
            pr_in_frame = 1'b0;
            pr_pos      = '0;
            aborted     = 1'b1;
        end
        pr_last = t;
        if (!pr_in_frame)
        begin
            if (b == START_BYTE)
            begin
                pr_in_frame = 1'b1;
                pr_pos      = FIRST_PAYLOAD_POS;
                pr_sum      = '0;
            end
        end
        else if (pr_pos >= FRAME_POS)
        begin
            pr_in_frame = 1'b0;
            pr_pos      = '0;
            st          = STATUS_OVERLONG;
        end
        else
        begin
            if (pr_pos >= FIRST_PAYLOAD_POS && pr_pos <= LAST_PAYLOAD_POS)
            begin
                pr_payload[pr_pos - FIRST_PAYLOAD_POS] = b;
                pr_sum = pr_sum + b;
            end
            else if (pr_pos == CHECK_POS)
            begin
                pr_check = b;
            end
            pr_pos = pr_pos + 5'd1;
            if (b == END_BYTE && pr_pos == FRAME_POS)
            begin
                st          = judge_frame();
                pr_in_frame = 1'b0;
                pr_pos      = '0;
            end
        end
        r           = held_rec;
        r.status    = st;
        r.timed_out = aborted;
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] exp,
                                 input logic [31:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, exp, act);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_side
        frx_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result expected none actual status %0h", $time, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("timed_out", 32'(want.timed_out), 32'(timed_out));
                compare_field("pwm_out", 32'(want.pwm), 32'(pwm_out));
                compare_field("ball_mode", 32'(want.ball_mode), 32'(ball_mode));
                compare_field("area_mode", 32'(want.area_mode), 32'(area_mode));
                compare_field("area_pwms", want.area_pwms, area_pwms);
                compare_field("area_speed_0", 32'(want.area_speeds[0]), 32'(area_speed_0));
                compare_field("area_speed_1", 32'(want.area_speeds[1]), 32'(area_speed_1));
                compare_field("area_speed_2", 32'(want.area_speeds[2]), 32'(area_speed_2));
                compare_field("area_speed_3", 32'(want.area_speeds[3]), 32'(area_speed_3));
            end
            rx_stall = quiet_rx ? 0 : $urandom_range(0, 16);
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (4) @(posedge clk);
    endtask

    task automatic next_stamp(input gap_mode_t m);
        logic [31:0] span;
        logic [31:0] delta;
        span  = 32'(lim_timeout);
        delta = '0;
        case (m)
            GAP_KEEP:
            begin
                if ($urandom_range(0, 9) == 0)
                    delta = span;
                else
                    delta = $urandom_range(0, span);
            end
            GAP_ABORT:
            begin
                if ($urandom_range(0, 7) == 0)
                    delta = $urandom_range(32'hFFFF_FFFF, span + 1);
                else
                    delta = span + 1 + $urandom_range(0, 40);
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    clock_ms = $urandom;
                else
                    delta = $urandom_range(0, 2 * span + 2);
            end
        endcase
        clock_ms = clock_ms + delta;
    endtask

    task automatic transmit_byte(input logic [7:0] b, input gap_mode_t m);
        int gap;
        if (drain_mode && $urandom_range(0, 9) == 0)
        begin
            wait_drained();
        end
        next_stamp(m);
        in_valid <= 1'b1;
        rx_byte  <= b;
        now_ms   <= clock_ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(rx_outcome(b, clock_ms));
        bytes_sent++;
        gap = quiet_tx ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] spd);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_index <= REG_MAX_SPEED;
        cfg_data  <= spd;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        lim_timeout = tmo;
        lim_speed   = spd;
        @(posedge clk);
    endtask

    function automatic logic [7:0] bad_mode();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 8'd0;
        else if (r == 1)
            return MODE_MAX + 8'd1;
        return 8'($urandom_range(5, 255));
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return FK_GOOD;
        if (r < 55) return FK_BAD_SUM;
        if (r < 62) return FK_BAD_BALL;
        if (r < 69) return FK_BAD_AREA;
        if (r < 77) return FK_FAST;
        if (r < 85) return FK_OVERLONG;
        if (r < 93) return FK_TRUNCATED;
        return FK_NOISE;
    endfunction

    task automatic fill_payload(input frame_kind_t k);
        int          i;
        int          slot;
        logic [15:0] spd;
        for (i = 0; i < PAYLOAD_LEN; i++)
        begin
            pl[i] = 8'($urandom);
        end
        pl[1] = 8'($urandom_range(1, 4));
        pl[2] = 8'($urandom_range(1, 4));
        for (i = 0; i < NUM_AREAS; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                spd = lim_speed;
            else
                spd = 16'($urandom_range(0, 32'(lim_speed)));
            pl[7 + 2 * i] = spd[7:0];
            pl[8 + 2 * i] = spd[15:8];
        end
        if ($urandom_range(0, 4) == 0)
        begin
            pl[3 + $urandom_range(0, 3)] = $urandom_range(0, 1) ? START_BYTE : END_BYTE;
        end
        case (k)
            FK_BAD_BALL: pl[1] = bad_mode();
            FK_BAD_AREA: pl[2] = bad_mode();
            FK_FAST:
            begin
                if (lim_speed != 16'hFFFF)
                begin
                    slot = $urandom_range(0, NUM_AREAS - 1);
                    spd  = 16'($urandom_range(32'(lim_speed) + 1, 65535));
                    pl[7 + 2 * slot] = spd[7:0];
                    pl[8 + 2 * slot] = spd[15:8];
                end
                else
                begin
                    pl[1] = bad_mode();
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_frame(input frame_kind_t k, input bit keep_pl);
        logic [7:0] chk;
        logic [7:0] b;
        int         n;
        int         i;
        gap_mode_t  first;
        first = pr_in_frame ? GAP_ABORT : GAP_FREE;
        if (k == FK_NOISE)
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                b = 8'($urandom);
                if (b == START_BYTE)
                    b = 8'h00;
                transmit_byte(b, (i == 0) ? first : GAP_FREE);
            end
        end
        else
        begin
            if (!keep_pl)
                fill_payload(k);
            transmit_byte(START_BYTE, first);
            if (k == FK_TRUNCATED)
            begin
                n = $urandom_range(0, 16);
                for (i = 0; i < n; i++)
                    transmit_byte(8'($urandom), GAP_KEEP);
            end
            else
            begin
                chk = 8'hFF;
                for (i = 0; i < PAYLOAD_LEN; i++)
                begin
                    chk = chk - pl[i];
                    transmit_byte(pl[i], GAP_KEEP);
                end
                if (k == FK_BAD_SUM)
                    chk = chk ^ 8'($urandom_range(1, 255));
                transmit_byte(chk, GAP_KEEP);
                if (k == FK_OVERLONG)
                begin
                    b = 8'($urandom);
                    if (b == END_BYTE)
                        b = ~b;
                    transmit_byte(b, GAP_KEEP);
                    transmit_byte(8'($urandom), GAP_KEEP);
                end
                else
                begin
                    transmit_byte(END_BYTE, GAP_KEEP);
                end
            end
        end
    endtask

    task automatic run_frames(input int count);
        int stop;
        stop = bytes_sent + count;
        while (bytes_sent < stop)
        begin
            if ($urandom_range(0, 5) == 0)
                quiet_tx = !quiet_tx;
            if ($urandom_range(0, 5) == 0)
                quiet_rx = !quiet_rx;
            send_frame(pick_kind(), 1'b0);
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    // Idle noise, then a good frame carrying start and end bytes as data
    // across the wrap of the millisecond counter, then an aborted frame.
    task automatic test_directed_cases();
        clock_ms = 32'hFFFF_FFC0;
        transmit_byte(8'h00, GAP_KEEP);
        transmit_byte(8'hFF, GAP_KEEP);
        transmit_byte(END_BYTE, GAP_KEEP);
        fill_payload(FK_GOOD);
        pl[0] = 8'hFF;
        pl[3] = START_BYTE;
        pl[4] = END_BYTE;
        pl[5] = 8'h00;
        pl[6] = 8'hFF;
        pl[7] = lim_speed[7:0];
        pl[8] = lim_speed[15:8];
        send_frame(FK_GOOD, 1'b1);
        transmit_byte(START_BYTE, GAP_FREE);
        transmit_byte(8'h12, GAP_KEEP);
        transmit_byte(8'h34, GAP_KEEP);
        transmit_byte(START_BYTE, GAP_ABORT);
    endtask

    task automatic test_reset_limits();
        run_frames(300);
    endtask

    task automatic test_lowest_limits();
        set_limits(16'd0, 16'd0);
        run_frames(150);
    endtask

    task automatic test_highest_limits();
        set_limits(16'hFFFF, 16'hFFFF);
        run_frames(250);
    endtask

    task automatic test_random_limits();
        int               i;
        logic [CFG_W-1:0] tmo;
        for (i = 0; i < 4; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                tmo = 16'($urandom_range(0, 300));
            else
                tmo = 16'($urandom);
            set_limits(tmo, 16'($urandom));
            run_frames(120);
        end
    endtask

    task automatic test_output_backpressure();
        int stop;
        wait_drained();
        rx_hold  = 300;
        quiet_tx = 1'b1;
        stop     = bytes_sent + 80;
        while (bytes_sent < stop)
            send_frame(pick_kind(), 1'b0);
        quiet_tx = 1'b0;
    endtask

    task automatic test_sender_drain();
        drain_mode = 1'b1;
        run_frames(100);
        drain_mode = 1'b0;
    endtask

    initial
    begin
        held_rec           = '0;
        held_rec.ball_mode = 3'd1;
        held_rec.area_mode = 3'd1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_reset_limits();
        test_lowest_limits();
        test_highest_limits();
        test_random_limits();
        test_output_backpressure();
        test_sender_drain();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
